FILE: design/udiv32_pkg.sv
// udiv32_pkg: widths, stage record and the radix-2 restoring step for the
// pipelined unsigned divider. No dependencies; used by the interfaces and
// the top level.
`timescale 1ns / 1ps

package udiv32_pkg;

    // width of the operand and result fields on the ports
    localparam int FIELD_WIDTH = 32;

    // datapath width; operands are cut to this many low bits when it is narrower
    localparam int DATA_WIDTH = 32;
    localparam int OPER_WIDTH = (DATA_WIDTH < FIELD_WIDTH) ? DATA_WIDTH : FIELD_WIDTH;

    // quotient bits resolved in each pipeline stage
    localparam int STAGE_BITS = 2;
    localparam int NUM_STAGES = (OPER_WIDTH + STAGE_BITS - 1) / STAGE_BITS;

    // dividend padded with leading zeros to a whole number of stages
    localparam int PAD_WIDTH = NUM_STAGES * STAGE_BITS;

    // partial state carried from stage to stage
    typedef struct packed {
        logic [OPER_WIDTH-1:0] rem;  // partial remainder, below den whenever den is nonzero
        logic [PAD_WIDTH-1:0]  quo;  // dividend bits shifting out, quotient bits in
        logic [OPER_WIDTH-1:0] den;  // divisor
        logic                  dbz;  // divisor was zero
    } stage_t;

    // STAGE_BITS steps of restoring division
    function automatic stage_t div_step(input stage_t s);
        stage_t                s_out;
        logic [OPER_WIDTH:0]   trial;
        logic [OPER_WIDTH:0]   diff;
        s_out = s;
        for (int k = 0; k < STAGE_BITS; k++)
        begin
            trial = {s_out.rem, s_out.quo[PAD_WIDTH-1]};
            diff  = trial - {1'b0, s_out.den};
            if (!diff[OPER_WIDTH])
            begin
                s_out.rem = diff[OPER_WIDTH-1:0];
                s_out.quo = {s_out.quo[PAD_WIDTH-2:0], 1'b1};
            end
            else
            begin
                s_out.rem = trial[OPER_WIDTH-1:0];
                s_out.quo = {s_out.quo[PAD_WIDTH-2:0], 1'b0};
            end
        end
        return s_out;
    endfunction

endpackage

FILE: design/udiv32_if.sv
// udiv32 channel interfaces: operand channel and result channel, each with
// valid/ready and payload. Depends on udiv32_pkg for field widths.
`timescale 1ns / 1ps

interface udiv32_in_if
    import udiv32_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] numerator;
    logic [FIELD_WIDTH-1:0] denominator;

    modport source (output valid, output numerator, output denominator, input ready);
    modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

interface udiv32_out_if
    import udiv32_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] quotient;
    logic                   divide_by_zero;

    modport source (output valid, output quotient, output divide_by_zero, input ready);
    modport sink   (input valid, input quotient, input divide_by_zero, output ready);
endinterface

FILE: design/unsigned_divider_32.sv
// unsigned_divider_32: pipelined restoring divider, STAGE_BITS quotient bits per stage.
// Each operand pair passes through every stage register in order; its result is offered from the last stage.
// Throughput: one transfer per cycle while results are taken; each stage holds one item and moves when the
// stage after it is empty or moving, so bubbles close up under a stalled result.
// Reset (rst_n, async, active low) clears every stage valid bit; data is not reset.
// Depends on udiv32_pkg and the channel interfaces in udiv32_if.sv.
`timescale 1ns / 1ps

module unsigned_divider_32
    import udiv32_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    udiv32_in_if.sink     operands,
    udiv32_out_if.source  result
);

    logic   [NUM_STAGES-1:0] valid_reg;
    logic   [NUM_STAGES-1:0] valid_next;
    logic   [NUM_STAGES:0]   stage_ready;
    stage_t                  stage_reg  [NUM_STAGES];
    stage_t                  stage_next [NUM_STAGES];
    stage_t                  stage_init;
    logic                    last_valid;
    stage_t                  last_stage;

    // seed the first stage from the operand transfer
    always_comb
    begin
        stage_init.rem = '0;
        stage_init.quo = PAD_WIDTH'(operands.numerator[OPER_WIDTH-1:0]);
        stage_init.den = operands.denominator[OPER_WIDTH-1:0];
        stage_init.dbz = (operands.denominator[OPER_WIDTH-1:0] == '0);
    end

    // a stage can take new data when it is empty or its content moves on
    assign stage_ready[NUM_STAGES] = result.ready;
    assign operands.ready          = stage_ready[0];

    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_stage
        assign stage_ready[i] = !valid_reg[i] || stage_ready[i+1];

        // next contents: the step applied to the previous stage
        if (i == 0)
        begin : g_first
            always_comb
            begin
                valid_next[i] = operands.valid;
                stage_next[i] = div_step(stage_init);
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                valid_next[i] = valid_reg[i-1];
                stage_next[i] = div_step(stage_reg[i-1]);
            end
        end

        // stage valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (stage_ready[i])
            begin
                valid_reg[i] <= valid_next[i];
            end
        end

        // stage payload, loaded only with a valid item
        always_ff @(posedge clk)
        begin
            if (stage_ready[i] && valid_next[i])
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    // result from the last stage
    assign last_valid = valid_reg[NUM_STAGES-1];
    assign last_stage = stage_reg[NUM_STAGES-1];

    assign result.valid          = last_valid;
    assign result.divide_by_zero = last_stage.dbz;
    assign result.quotient       = last_stage.dbz ? '0
                                   : FIELD_WIDTH'(last_stage.quo[OPER_WIDTH-1:0]);

    // a finished remainder is always below a nonzero divisor
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (last_valid && !last_stage.dbz) |-> (last_stage.rem < last_stage.den))
        else $error("remainder not below divisor at last stage");

    // operand channel is held off only when every stage is occupied
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !operands.ready |-> (&valid_reg))
        else $error("operand channel blocked with an empty stage");

    // a stalled result stays in place
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (last_valid && !result.ready) |=>
            (last_valid && $stable(last_stage.quo) && $stable(last_stage.dbz)))
        else $error("stalled result lost or changed");

    // an accepted operand pair lands in the first stage
    a_first_load: assert property (@(posedge clk) disable iff (!rst_n)
        (operands.valid && operands.ready) |=> valid_reg[0])
        else $error("accepted operands not captured");

endmodule

FILE: tb/unsigned_divider_32_tb.sv
// unsigned_divider_32_tb: self-checking testbench for the pipelined unsigned divider.
// Drives operand transfers with random gaps, predicts each quotient and checks results.
// Depends on udiv32_pkg, the channel interfaces in udiv32_if.sv and unsigned_divider_32.
`timescale 1ns / 1ps

module unsigned_divider_32_tb;

    import udiv32_pkg::*;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] quotient;
        logic                   divide_by_zero;
    } quotient_result_t;

    localparam logic [FIELD_WIDTH-1:0] ALL_ONES = '1;
    localparam logic [FIELD_WIDTH-1:0] TOP_BIT  = {1'b1, {(FIELD_WIDTH-1){1'b0}}};

    logic clk;
    logic rst_n;

    udiv32_in_if  operands ();
    udiv32_out_if result ();

    unsigned_divider_32 i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands),
        .result   (result)
    );

    // quotients still owed by the divider, oldest first
    quotient_result_t expected_quotients[$];
    int               mismatch_count;
    int               source_idle_pct;
    int               sink_stall_pct;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #15_000_000;
        $display("unsigned_divider_32 verification failed");
        $finish;
    end

    // division as the datapath sees it: operands cut to the datapath width
    function automatic quotient_result_t predict_quotient(
        input logic [FIELD_WIDTH-1:0] num,
        input logic [FIELD_WIDTH-1:0] den
    );
        logic [63:0]      oper_mask;
        logic [63:0]      n;
        logic [63:0]      d;
        logic [63:0]      q;
        quotient_result_t r;
        oper_mask = (64'd1 << OPER_WIDTH) - 64'd1;
        n = 64'(num) & oper_mask;
        d = 64'(den) & oper_mask;
        if (d == 64'd0)
        begin
            r.quotient       = '0;
            r.divide_by_zero = 1'b1;
        end
        else
        begin
            q                = n / d;
            r.quotient       = q[FIELD_WIDTH-1:0];
            r.divide_by_zero = 1'b0;
        end
        return r;
    endfunction

    // idle length: mostly short, a few long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // operand pair drawn from a mix of interesting shapes
    function automatic void random_operands(
        output logic [FIELD_WIDTH-1:0] num,
        output logic [FIELD_WIDTH-1:0] den
    );
        logic [FIELD_WIDTH-1:0] k;
        num = $urandom;
        den = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2: ;
            3: den = $urandom_range(1, 16);
            4: den = '0;
            5: den = TOP_BIT >> $urandom_range(0, FIELD_WIDTH - 1);
            6:
            begin
                if (den == '0)
                    den = 1;
                num = $urandom % den;
            end
            7:
            begin
                // exact multiples and one below them
                den = $urandom_range(1, 65535);
                k   = $urandom_range(0, ALL_ONES / den);
                num = den * k;
                if (k != '0 && $urandom_range(0, 1))
                    num = num - 1;
            end
            8:
            begin
                num = ALL_ONES ^ (FIELD_WIDTH'($urandom_range(0, 1)) << $urandom_range(0, 31));
                den = $urandom_range(1, 255);
            end
            default: den = $urandom & 32'hFFFF_0000;
        endcase
    endfunction

    // one operand transfer; called and returns on a falling edge
    task automatic send_operands(
        input logic [FIELD_WIDTH-1:0] num,
        input logic [FIELD_WIDTH-1:0] den
    );
        int gap;
        operands.valid       <= 1'b1;
        operands.numerator   <= num;
        operands.denominator <= den;
        do
            @(posedge clk);
        while (operands.ready !== 1'b1);
        expected_quotients.push_back(predict_quotient(num, den));
        @(negedge clk);
        gap = ($urandom_range(0, 99) < source_idle_pct) ? idle_length() : 0;
        if (gap > 0)
        begin
            operands.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // drop valid and wait for every owed quotient
    task automatic drain_results();
        operands.valid <= 1'b0;
        while (expected_quotients.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed_cases();
        source_idle_pct = 30;
        sink_stall_pct  = 30;
        send_operands('0, 1);
        send_operands(ALL_ONES, 1);
        send_operands(ALL_ONES, ALL_ONES);
        send_operands('0, ALL_ONES);
        send_operands(1, ALL_ONES);
        send_operands(ALL_ONES - 1, ALL_ONES);
        send_operands(ALL_ONES, ALL_ONES - 1);
        send_operands(ALL_ONES, 2);
        send_operands(TOP_BIT, TOP_BIT);
        send_operands(TOP_BIT, 1);
        send_operands(1, TOP_BIT);
        send_operands(TOP_BIT - 1, TOP_BIT);
        send_operands(100, 7);
        send_operands(7, 3);
        send_operands(32'h5555_5555, 32'h0000_0003);
        send_operands(32'hAAAA_AAAA, 32'h5555_5555);
        // zero divisor with various dividends
        send_operands('0, '0);
        send_operands(ALL_ONES, '0);
        send_operands(12345, '0);
        // divisor with only upper bits set, zero if the datapath is narrowed
        send_operands(ALL_ONES, 32'hFFFF_0000);
        send_operands(32'h0000_FFFF, TOP_BIT);
        send_operands(32'h1234_5678, 32'h0001_0000);
        drain_results();
    endtask

    // full rate on both sides
    task automatic test_back_to_back();
        logic [FIELD_WIDTH-1:0] num;
        logic [FIELD_WIDTH-1:0] den;
        source_idle_pct = 0;
        sink_stall_pct  = 0;
        repeat (300)
        begin
            random_operands(num, den);
            send_operands(num, den);
        end
        drain_results();
    endtask

    // sender never idles while the result side stalls hard
    task automatic test_stalled_results();
        logic [FIELD_WIDTH-1:0] num;
        logic [FIELD_WIDTH-1:0] den;
        source_idle_pct = 0;
        sink_stall_pct  = 60;
        repeat (300)
        begin
            random_operands(num, den);
            send_operands(num, den);
        end
        drain_results();
    endtask

    // idling on both sides, levels changing every stretch
    task automatic test_random_traffic();
        logic [FIELD_WIDTH-1:0] num;
        logic [FIELD_WIDTH-1:0] den;
        repeat (9)
        begin
            source_idle_pct = $urandom_range(0, 2) * 25;
            sink_stall_pct  = $urandom_range(0, 2) * 25;
            repeat (150)
            begin
                random_operands(num, den);
                send_operands(num, den);
            end
        end
        drain_results();
    endtask

    // result side ready with random stalls
    initial
    begin : result_ready_driver
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < sink_stall_pct)
            begin
                result.ready <= 1'b0;
                repeat (idle_length()) @(negedge clk);
            end
            result.ready <= 1'b1;
        end
    end

    // compare each result transfer with the oldest owed quotient
    initial
    begin : result_checker
        quotient_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && result.valid === 1'b1 && result.ready === 1'b1)
            begin
                if (expected_quotients.size() == 0)
                begin
                    $display("%0t: unexpected result transfer, quotient %h divide_by_zero %b",
                             $time, result.quotient, result.divide_by_zero);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_quotients.pop_front();
                    if (result.quotient !== want.quotient)
                    begin
                        $display("%0t: quotient mismatch, expected %h actual %h",
                                 $time, want.quotient, result.quotient);
                        mismatch_count++;
                    end
                    if (result.divide_by_zero !== want.divide_by_zero)
                    begin
                        $display("%0t: divide_by_zero mismatch, expected %b actual %b",
                                 $time, want.divide_by_zero, result.divide_by_zero);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // reset, test sequence and verdict
    initial
    begin
        mismatch_count       = 0;
        source_idle_pct      = 0;
        sink_stall_pct       = 0;
        rst_n                = 1'b0;
        operands.valid       = 1'b0;
        operands.numerator   = '0;
        operands.denominator = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_back_to_back();
        test_stalled_results();
        test_random_traffic();

        // let any stray result show up
        repeat (NUM_STAGES + 8) @(negedge clk);
        if (mismatch_count == 0 && expected_quotients.size() == 0)
            $display("unsigned_divider_32 verification clean");
        else
            $display("unsigned_divider_32 verification failed");
        $finish;
    end

endmodule
